// File: rtl/dq_pkg.sv
package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int ENTRY_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_PEEK       = 3'd5
    } t_cmd;

    typedef struct packed {
        logic        [CMD_W-1:0]  command;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  back_value;
        logic        [ENTRY_W-1:0] entry_count;
        logic                      is_empty;
        logic                      push_rejected;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/dq_ctrl.sv
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dq_pkg::t_dp_stat i_stat,
    output dq_pkg::t_dp_cmd  o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dq_datapath.sv
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dq_pkg::t_in_item  i_in_item,
    input  dq_pkg::t_dp_cmd   i_cmd,
    output dq_pkg::t_dp_stat  o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output dq_pkg::t_out_item o_out_item
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];

    t_in_item          r_item;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic              r_rejected;
    logic [DATA_W-1:0] r_front_rd;
    logic [DATA_W-1:0] r_back_rd;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     tail_inc;
    logic [AW-1:0]     tail_dec;
    logic              full;
    logic              empty;
    logic              is_push;
    logic              do_write;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     n_tail;
    logic [CW-1:0]     n_count;
    logic              n_rejected;
    t_out_item         n_out_item;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign is_push  = (r_item.command == CMD_PUSH_BACK) || (r_item.command == CMD_PUSH_FRONT);
    assign do_write = i_cmd.exec && is_push && !full;
    assign wr_addr  = (r_item.command == CMD_PUSH_BACK) ? r_tail : head_dec;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_rejected = 1'b0;
        unique case (r_item.command)
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_rejected = 1'b1;
                end else begin
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_rejected = 1'b1;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (!empty) begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (!empty) begin
                    n_tail  = tail_dec;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
                // peek and unused codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_addr] <= r_item.push_value;
        end
        if (i_cmd.read) begin
            r_front_rd <= r_mem[r_head];
            r_back_rd  <= r_mem[tail_dec];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_rejected <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_rejected <= n_rejected;
        end
    end

    always_comb begin
        n_out_item.front_value   = empty ? '0 : r_front_rd;
        n_out_item.back_value    = empty ? '0 : r_back_rd;
        n_out_item.entry_count   = ENTRY_W'(r_count);
        n_out_item.is_empty      = empty;
        n_out_item.push_rejected = r_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

// File: rtl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit values in a circular store of DEPTH
// slots. Each input transaction carries one command (push back, push front,
// pop front, pop back, clear, peek; codes six and seven act as peek) and
// yields exactly one result transaction with the front and back values
// (zero when empty), the count, an empty flag and a flag for a push dropped
// on a full queue. A pop on an empty queue changes nothing. A command passes
// in turn through capture, pointer update with the slot write, a registered
// two-port read of the store, and the load of the output register; the
// next command is taken while a result still waits in that register, and a
// stall on the result side adds its cycles only when a second result is
// ready before the first is taken. Reset clears pointers and count at once,
// so there is no clearing pass; only written slots reach the output.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dq_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dq_pkg::t_out_item o_out_item
);
    import dq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: rtl/dq_checker.sv
module dq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input dq_pkg::t_in_item  i_in_item,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input dq_pkg::t_out_item o_out_item
);
    import dq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result dropped or changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("new transaction taken while a command is in progress");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_empty |->
            o_out_item.front_value == '0 && o_out_item.back_value == '0
            && o_out_item.entry_count == '0)
        else $error("empty queue reports nonzero values");

    a_count_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.entry_count != '0 |-> !o_out_item.is_empty)
        else $error("empty flag set with nonzero count");

    a_result_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a command in progress");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);

// File: tb/sv/double_ended_queue_core_tb.sv
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 1120;
    localparam int MAX_REPORTS  = 10;

    // codes six and seven carry no name in the package and act as peek
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct {
        t_in_item    item;
        int unsigned reps;
        bit          typed_valid;
        t_out_item   typed_result;
    } t_directed_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // mirror of the queue contents
    logic signed [DATA_W-1:0] slot_mirror [DEPTH];
    logic [PTR_W-1:0]         head_ptr = '0;
    logic [PTR_W-1:0]         tail_ptr = '0;
    int                       occupancy = 0;

    t_out_item     pending_results [$];
    t_directed_row directed_rows [$];
    int            mismatches = 0;
    bit            steady_flow = 1'b0;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic t_out_item outcome(logic signed [DATA_W-1:0] front,
                                          logic signed [DATA_W-1:0] back, int count,
                                          int empty, int rejected);
        t_out_item r;
        r.front_value   = front;
        r.back_value    = back;
        r.entry_count   = ENTRY_W'(count);
        r.is_empty      = (empty != 0);
        r.push_rejected = (rejected != 0);
        return r;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value,
                                    int unsigned reps, int typed_valid, t_out_item typed_result);
        t_directed_row row;
        row.item.command    = cmd;
        row.item.push_value = value;
        row.reps            = reps;
        row.typed_valid     = (typed_valid != 0);
        row.typed_result    = typed_result;
        directed_rows       = {directed_rows, row};
    endfunction

    // advance the mirror by one command and return the result it should give
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (occupancy >= DEPTH) begin
                    r.push_rejected = 1'b1;
                end else if (it.command == CMD_PUSH_BACK) begin
                    slot_mirror[tail_ptr] = it.push_value;
                    tail_ptr = tail_ptr + 1'b1;
                    occupancy++;
                end else begin
                    head_ptr = head_ptr - 1'b1;
                    slot_mirror[head_ptr] = it.push_value;
                    occupancy++;
                end
            end
            CMD_POP_FRONT: begin
                if (occupancy != 0) begin
                    head_ptr = head_ptr + 1'b1;
                    occupancy--;
                end
            end
            CMD_POP_BACK: begin
                if (occupancy != 0) begin
                    tail_ptr = tail_ptr - 1'b1;
                    occupancy--;
                end
            end
            CMD_CLEAR: begin
                head_ptr  = '0;
                tail_ptr  = '0;
                occupancy = 0;
            end
            default: ;
        endcase
        if (occupancy != 0) begin
            r.front_value = slot_mirror[head_ptr];
            r.back_value  = slot_mirror[PTR_W'(tail_ptr - 1'b1)];
        end
        r.entry_count = ENTRY_W'(occupancy);
        r.is_empty    = (occupancy == 0);
        return r;
    endfunction

    function automatic t_in_item random_command(t_mix mix);
        t_in_item it;
        int       roll;
        int       push_pct;
        int       clear_pct;
        clear_pct = (mix == MIX_FILL) ? 1 : 3;
        case (mix)
            MIX_FILL:  push_pct = 65;
            MIX_DRAIN: push_pct = 25;
            default:   push_pct = 46;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < clear_pct) begin
            it.command = CMD_CLEAR;
        end else if (roll < clear_pct + 5) begin
            it.command = CMD_W'($urandom_range(CMD_PEEK, CMD_SPARE_7));
        end else if (roll < clear_pct + 5 + push_pct) begin
            it.command = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
            it.command = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        case ($urandom_range(0, 15))
            0:       it.push_value = MAX_VAL;
            1:       it.push_value = MIN_VAL;
            2:       it.push_value = '0;
            3:       it.push_value = '1;
            default: it.push_value = $urandom;
        endcase
        return it;
    endfunction

    task automatic send_command(input t_in_item it, input bit typed_valid,
                                input t_out_item typed_result);
        int        gap;
        t_out_item predicted;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        // stall is settled by the falling edge, so look there before the accepting edge
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        predicted = apply_command(it);
        pending_results = {pending_results, (typed_valid ? typed_result : predicted)};
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: exp front=%0d back=%0d count=%0d empty=%b rej=%b", $realtime,
                     what, want.front_value, want.back_value, want.entry_count,
                     want.is_empty, want.push_rejected);
            $display("%0t %s: got front=%0d back=%0d count=%0d empty=%b rej=%b", $realtime,
                     what, got.front_value, got.back_value, got.entry_count,
                     got.is_empty, got.push_rejected);
        end
    endtask

    // sampled on the falling edge ahead of the edge that takes the transaction
    always @(negedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, o_out_item);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (want.front_value !== o_out_item.front_value ||
                    want.back_value !== o_out_item.back_value ||
                    want.entry_count !== o_out_item.entry_count ||
                    want.is_empty !== o_out_item.is_empty ||
                    want.push_rejected !== o_out_item.push_rejected) begin
                    note_mismatch("result mismatch", want, o_out_item);
                end
            end
        end
    end

    // result side: hold stall for a drawn number of cycles, then take one transaction
    initial begin : result_sink
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(negedge i_clk);
            while (!(o_out_valid && i_rst_n)) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_mix mix;
        mix = MIX_EVEN;

        add_row(CMD_PEEK,       '0,            1,  1, outcome('0, '0, 0, 1, 0));
        add_row(CMD_POP_FRONT,  '0,            1,  1, outcome('0, '0, 0, 1, 0));
        add_row(CMD_POP_BACK,   '1,            1,  1, outcome('0, '0, 0, 1, 0));
        add_row(CMD_PUSH_BACK,  MAX_VAL,       1,  1, outcome(MAX_VAL, MAX_VAL, 1, 0, 0));
        add_row(CMD_PUSH_FRONT, MIN_VAL,       1,  1, outcome(MIN_VAL, MAX_VAL, 2, 0, 0));
        add_row(CMD_SPARE_6,    '1,            1,  1, outcome(MIN_VAL, MAX_VAL, 2, 0, 0));
        add_row(CMD_SPARE_7,    '0,            1,  1, outcome(MIN_VAL, MAX_VAL, 2, 0, 0));
        add_row(CMD_PUSH_BACK,  '1,            1,  1, outcome(MIN_VAL, '1, 3, 0, 0));
        add_row(CMD_POP_FRONT,  '0,            1,  1, outcome(MAX_VAL, '1, 2, 0, 0));
        add_row(CMD_POP_BACK,   '0,            1,  1, outcome(MAX_VAL, MAX_VAL, 1, 0, 0));
        add_row(CMD_POP_BACK,   '0,            1,  1, outcome('0, '0, 0, 1, 0));
        // push front on an empty queue wraps the head below slot zero
        add_row(CMD_PUSH_FRONT, '0,            1,  1, outcome('0, '0, 1, 0, 0));
        add_row(CMD_CLEAR,      '0,            1,  1, outcome('0, '0, 0, 1, 0));
        add_row(CMD_PUSH_BACK,  32'h5A5A_5A5A, 16, 0, '0);
        add_row(CMD_PUSH_FRONT, 32'hA5A5_A5A5, 1,  1,
                outcome(32'h5A5A_5A5A, 32'h5A5A_5A5A, 16, 0, 1));
        add_row(CMD_PUSH_BACK,  32'hA5A5_A5A5, 1,  1,
                outcome(32'h5A5A_5A5A, 32'h5A5A_5A5A, 16, 0, 1));
        add_row(CMD_CLEAR,      '0,            1,  1, outcome('0, '0, 0, 1, 0));
        add_row(CMD_PUSH_FRONT, 32'h1234_5678, 3,  0, '0);
        add_row(CMD_POP_BACK,   '0,            1,  0, '0);

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps) begin
                send_command(directed_rows[r].item, directed_rows[r].typed_valid,
                             directed_rows[r].typed_result);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                mix = t_mix'($urandom_range(MIX_FILL, MIX_EVEN));
            end
            if (n % 100 == 0) begin
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            send_command(random_command(mix), 1'b0, '0);
        end
        steady_flow = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
